// File: src/rlcsd_pkg.sv
// shared types and constants of the rgb led chain serial driver
`timescale 1ns / 1ps

package rlcsd_pkg;

    localparam int CHAIN_LEN_DEF = 64;
    localparam int COLOUR_W      = 24;
    localparam int BITS_PER_LED  = 24;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [9:0]  BIT_PERIOD_RST = 10'd60;
    localparam logic [9:0]  ZERO_HIGH_RST  = 10'd19;
    localparam logic [9:0]  ONE_HIGH_RST   = 10'd39;
    localparam logic [15:0] RESET_TICKS_RST = 16'd2460;
    localparam logic [6:0]  ACTIVE_LEDS_RST = 7'd64;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_START = 2'd1,
        ACT_TICK  = 2'd2
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BIT_PERIOD  = 3'd0,
        CFG_ZERO_HIGH   = 3'd1,
        CFG_ONE_HIGH    = 3'd2,
        CFG_RESET_TICKS = 3'd3,
        CFG_ACTIVE_LEDS = 3'd4
    } cfg_idx_t;

    // status of the store toward the line sequencer
    typedef struct packed {
        logic                copy_busy;
        logic                load_first;
        logic [COLOUR_W-1:0] first_colour;
    } store_status_t;

endpackage

// File: src/rlcsd_store.sv
// colour store, frame store and the snapshot copy sweep between them
`timescale 1ns / 1ps

module rlcsd_store #(
    parameter int CHAIN_LEN = rlcsd_pkg::CHAIN_LEN_DEF,
    parameter int IW        = (CHAIN_LEN > 1) ? $clog2(CHAIN_LEN) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [IW-1:0]                 wr_idx,
    input  logic [rlcsd_pkg::COLOUR_W-1:0] wr_colour,
    input  logic                          copy_start,
    input  logic [IW-1:0]                 frame_rd_addr,
    output logic [rlcsd_pkg::COLOUR_W-1:0] frame_rd_data,
    output rlcsd_pkg::store_status_t      status
);
    import rlcsd_pkg::*;

    logic [COLOUR_W-1:0] colour_mem [CHAIN_LEN];
    logic [COLOUR_W-1:0] frame_mem  [CHAIN_LEN];
    logic [CHAIN_LEN-1:0] valid_reg;

    logic                copy_act_reg;
    logic [IW-1:0]       copy_cnt_reg;
    logic                rd_pend_reg;
    logic [IW-1:0]       rd_idx_reg;
    logic [COLOUR_W-1:0] rd_data_reg;
    logic                rd_valid_reg;
    logic [COLOUR_W-1:0] copy_colour;

    // never-written entries read as zero
    assign copy_colour = rd_valid_reg ? rd_data_reg : '0;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            colour_mem[wr_idx] <= wr_colour;
        end
        if (copy_act_reg)
        begin
            rd_data_reg <= colour_mem[copy_cnt_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_pend_reg)
        begin
            frame_mem[rd_idx_reg] <= copy_colour;
        end
        frame_rd_data <= frame_mem[frame_rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            copy_act_reg <= 1'b0;
            copy_cnt_reg <= '0;
            rd_pend_reg  <= 1'b0;
            rd_idx_reg   <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
            rd_pend_reg <= copy_act_reg;
            if (copy_act_reg)
            begin
                rd_idx_reg   <= copy_cnt_reg;
                rd_valid_reg <= valid_reg[copy_cnt_reg];
                copy_cnt_reg <= copy_cnt_reg + IW'(1);
                if (copy_cnt_reg == IW'(CHAIN_LEN - 1))
                begin
                    copy_act_reg <= 1'b0;
                end
            end
            else if (copy_start)
            begin
                copy_act_reg <= 1'b1;
                copy_cnt_reg <= '0;
            end
        end
    end

    assign status.copy_busy    = copy_act_reg | rd_pend_reg;
    assign status.load_first   = rd_pend_reg && (rd_idx_reg == '0);
    assign status.first_colour = copy_colour;

endmodule

// File: src/rgb_led_chain_serial_driver_top.sv
// top level of the rgb led chain serial driver: handshake, config and line sequencer
`timescale 1ns / 1ps

// single-wire rgb led chain driver
// input stream: s_tuser carries the action (write colour, start frame, tick),
//   s_tdata carries led index and green, red, blue for a write
// output stream: one result transaction per input transaction with the line
//   level of that tick, whether a write or start was taken, and busy after it
// latency: a result is registered and shows in the cycle after its input
// throughput: one transaction per cycle for writes and ticks while results are
//   taken; a taken start holds s_tready low while the copy sweep moves the
//   colour store into the frame store, one entry per cycle
// the next led colour is prefetched from the frame store memory while the
//   current one shifts out, so ticks run back to back through a whole frame
// leds go out green, red, blue, msb first; after the last active led the line
//   stays low for reset_ticks ticks, then busy clears
// reset: colour store reads as zero, config takes its defaults, line idle
// stall: while m_tready is low and a result waits, no new input is taken
// config writes are taken at once on cfg_we and are meant for idle times only

module rgb_led_chain_serial_driver_top #(
    parameter int CHAIN_LEN = rlcsd_pkg::CHAIN_LEN_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // slave side
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [31:0]                     s_tdata,  // led_index, green, red, blue
    input  logic [1:0]                      s_tuser,  // action
    // master side
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,  // line_level, accepted, busy_res, zeros
    // config write port
    input  logic                            cfg_we,
    input  logic [rlcsd_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [rlcsd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rlcsd_pkg::*;

    localparam int IW = (CHAIN_LEN > 1) ? $clog2(CHAIN_LEN) : 1;
    localparam int PW = $clog2(CHAIN_LEN + 1);

    // config registers
    logic [9:0]  bit_period_reg;
    logic [9:0]  zero_high_reg;
    logic [9:0]  one_high_reg;
    logic [15:0] reset_ticks_reg;
    logic [6:0]  active_leds_reg;

    // sequencer state
    logic                sending_reg, sending_next;
    logic                in_reset_reg, in_reset_next;
    logic [PW-1:0]       led_ptr_reg, led_ptr_next;
    logic [4:0]          bit_ptr_reg, bit_ptr_next;
    logic [15:0]         tick_cnt_reg, tick_cnt_next;
    logic [COLOUR_W-1:0] shifter_reg, shifter_next;

    // result register
    logic m_valid_reg;
    logic level_reg, taken_reg, busy_reg;

    // input fields
    action_t       action;
    logic [7:0]    led_index;
    logic [7:0]    green, red, blue;

    logic          in_acc;
    logic          idx_ok;
    logic          level, taken;
    logic          wr_en, copy_start;
    logic [9:0]    high_ticks;
    logic [15:0]   tick_inc;
    logic [PW-1:0] led_inc;
    logic [PW-1:0] frame_leds;

    logic [COLOUR_W-1:0] frame_rd_data;
    store_status_t       st;

    assign action    = action_t'(s_tuser);
    assign led_index = s_tdata[7:0];
    assign green     = s_tdata[15:8];
    assign red       = s_tdata[23:16];
    assign blue      = s_tdata[31:24];

    // input blocked during the copy sweep and while a result is stuck
    assign s_tready = !st.copy_busy && (!m_valid_reg || m_tready);
    assign in_acc   = s_tvalid && s_tready;

    assign idx_ok = {1'b0, led_index} < 9'(CHAIN_LEN);
    assign wr_en  = in_acc && (action == ACT_WRITE) && idx_ok;

    // active count clamped to one .. CHAIN_LEN
    always_comb
    begin
        if (active_leds_reg == '0)
        begin
            frame_leds = PW'(1);
        end
        else if ({2'b0, active_leds_reg} > 9'(CHAIN_LEN))
        begin
            frame_leds = PW'(CHAIN_LEN);
        end
        else
        begin
            frame_leds = PW'(active_leds_reg);
        end
    end

    assign high_ticks = shifter_reg[COLOUR_W-1] ? one_high_reg : zero_high_reg;
    assign tick_inc   = tick_cnt_reg + 16'd1;
    assign led_inc    = led_ptr_reg + PW'(1);

    always_comb
    begin
        sending_next  = sending_reg;
        in_reset_next = in_reset_reg;
        led_ptr_next  = led_ptr_reg;
        bit_ptr_next  = bit_ptr_reg;
        tick_cnt_next = tick_cnt_reg;
        shifter_next  = shifter_reg;
        level         = 1'b0;
        taken         = 1'b0;
        copy_start    = 1'b0;

        // first colour arrives from the copy sweep, no item is taken then
        if (st.load_first)
        begin
            shifter_next = st.first_colour;
        end

        if (in_acc)
        begin
            unique case (action)
                ACT_WRITE:
                begin
                    taken = idx_ok;
                end
                ACT_START:
                begin
                    if (!sending_reg && !in_reset_reg)
                    begin
                        sending_next  = 1'b1;
                        in_reset_next = 1'b0;
                        led_ptr_next  = '0;
                        bit_ptr_next  = '0;
                        tick_cnt_next = '0;
                        copy_start    = 1'b1;
                        taken         = 1'b1;
                    end
                end
                ACT_TICK:
                begin
                    if (sending_reg)
                    begin
                        level = tick_cnt_reg < {6'b0, high_ticks};
                        if (tick_inc >= {6'b0, bit_period_reg})
                        begin
                            // end of bit period
                            tick_cnt_next = '0;
                            shifter_next  = {shifter_reg[COLOUR_W-2:0], 1'b0};
                            if (bit_ptr_reg == 5'(BITS_PER_LED - 1))
                            begin
                                bit_ptr_next = '0;
                                led_ptr_next = led_inc;
                                if (led_inc >= frame_leds)
                                begin
                                    sending_next  = 1'b0;
                                    in_reset_next = 1'b1;
                                end
                                else
                                begin
                                    // prefetched colour of the next led
                                    shifter_next = frame_rd_data;
                                end
                            end
                            else
                            begin
                                bit_ptr_next = bit_ptr_reg + 5'd1;
                            end
                        end
                        else
                        begin
                            tick_cnt_next = tick_inc;
                        end
                    end
                    else if (in_reset_reg)
                    begin
                        if (tick_inc >= reset_ticks_reg)
                        begin
                            tick_cnt_next = '0;
                            in_reset_next = 1'b0;
                        end
                        else
                        begin
                            tick_cnt_next = tick_inc;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_period_reg  <= BIT_PERIOD_RST;
            zero_high_reg   <= ZERO_HIGH_RST;
            one_high_reg    <= ONE_HIGH_RST;
            reset_ticks_reg <= RESET_TICKS_RST;
            active_leds_reg <= ACTIVE_LEDS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                CFG_BIT_PERIOD:  bit_period_reg  <= cfg_data[9:0];
                CFG_ZERO_HIGH:   zero_high_reg   <= cfg_data[9:0];
                CFG_ONE_HIGH:    one_high_reg    <= cfg_data[9:0];
                CFG_RESET_TICKS: reset_ticks_reg <= cfg_data;
                CFG_ACTIVE_LEDS: active_leds_reg <= cfg_data[6:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sending_reg  <= 1'b0;
            in_reset_reg <= 1'b0;
            led_ptr_reg  <= '0;
            bit_ptr_reg  <= '0;
            tick_cnt_reg <= '0;
            shifter_reg  <= '0;
            m_valid_reg  <= 1'b0;
            level_reg    <= 1'b0;
            taken_reg    <= 1'b0;
            busy_reg     <= 1'b0;
        end
        else
        begin
            sending_reg  <= sending_next;
            in_reset_reg <= in_reset_next;
            led_ptr_reg  <= led_ptr_next;
            bit_ptr_reg  <= bit_ptr_next;
            tick_cnt_reg <= tick_cnt_next;
            shifter_reg  <= shifter_next;
            if (in_acc)
            begin
                m_valid_reg <= 1'b1;
                level_reg   <= level;
                taken_reg   <= taken;
                busy_reg    <= sending_next | in_reset_next;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, busy_reg, taken_reg, level_reg};

    rlcsd_store #(
        .CHAIN_LEN (CHAIN_LEN),
        .IW        (IW)
    ) u_store (
        .clk           (clk),
        .rst_n         (rst_n),
        .wr_en         (wr_en),
        .wr_idx        (led_index[IW-1:0]),
        .wr_colour     ({green, red, blue}),
        .copy_start    (copy_start),
        .frame_rd_addr (led_inc[IW-1:0]),
        .frame_rd_data (frame_rd_data),
        .status        (st)
    );

endmodule
